// ----- rtl/core/krd_pkg.sv -----
// Shared types, constants and coefficient table for the keypoint row decoder.
`default_nettype none

package krd_pkg;

    localparam int CLASS_SLOTS = 9;
    localparam int COLOR_SLOTS = 4;
    localparam int CORNER_LANES = 8;

    localparam int EXP_STEPS = 12;
    localparam int DIV_Q_W = 17;
    localparam int DIV_NUM_W = 41;
    localparam int DIV_DEN_W = 28;
    localparam int SQRT_STEPS = 16;

    localparam int EXP_LAT = EXP_STEPS;
    localparam int DIV_LAT = DIV_Q_W;
    localparam int SQRT_LAT = SQRT_STEPS + 1;

    typedef logic [15:0] exp_arg_t;
    typedef logic [24:0] exp_val_t;
    typedef logic [DIV_NUM_W-1:0] div_num_t;
    typedef logic [DIV_DEN_W-1:0] div_den_t;
    typedef logic [31:0] sqrt_arg_t;
    typedef logic [13:0] edge_t;

    localparam exp_val_t EXP_ONE = 25'h100_0000;

    localparam logic [1:0] REG_TARGET_COLOR = 2'd0;
    localparam logic [1:0] REG_CONF_THRESHOLD = 2'd1;

    localparam logic [1:0] COLOR_0 = 2'd0;
    localparam logic [1:0] COLOR_1 = 2'd1;

    localparam logic [1:0] TARGET_COLOR_RESET = 2'd2;
    localparam logic [15:0] CONF_THRESHOLD_RESET = 16'd42598;

    typedef struct packed {
        logic [63:0]        corners_a;
        logic [63:0]        corners_b;
        logic signed [15:0] objectness_logit;
        logic [63:0]        color_logits;
        logic [63:0]        class_logits_low;
        logic [63:0]        class_logits_high;
        logic signed [15:0] class_logit_last;
    } row_t;

    // exp(-2^(k-8)) in Q0.24
    function automatic logic [23:0] exp_coef(input int k);
        logic [23:0] c;
        case (k)
            0:       c = 24'd16711808;
            1:       c = 24'd16646655;
            2:       c = 24'd16517109;
            3:       c = 24'd16261035;
            4:       c = 24'd15760736;
            5:       c = 24'd14805841;
            6:       c = 24'd13066109;
            7:       c = 24'd10175896;
            8:       c = 24'd6171993;
            9:       c = 24'd2270549;
            10:      c = 24'd307285;
            11:      c = 24'd5628;
            default: c = 24'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/keypoint_detection_row_decoder.sv -----
// Top level of the keypoint detector row decoder.
//
// Usage:
//   Rows enter on the row channel (row_valid/row_ready), one per transfer.
//   Each kept row leaves as one transfer on the det channel
//   (det_valid/det_ready); a dropped row leaves nothing.
//   Registers are written on the cfg channel: index 0 is target_color,
//   index 1 is confidence_threshold. cfg_ready is always high.
//   The longest path is the geometry path: three front stages, the
//   squared sum, the 17-stage square root and the 17-stage ratio
//   divider in series, followed by the output register.
//   Throughput: one row per cycle, in every cycle the output is free.
//   All stages advance together; row_ready is low only while a result
//   waits with det_ready low, and then the whole pipeline holds.
//   Reset clears all valid bits and loads target_color = 2 and
//   confidence_threshold = 42598 (0.65 in Q0.16).
`default_nettype none

module keypoint_detection_row_decoder import krd_pkg::*;
#(
    parameter int COORD_LIMIT = 640,
    parameter int NUM_CLASSES = 9,
    parameter int NUM_COLORS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               row_valid,
    output logic               row_ready,
    input  logic [63:0]        corners_a,
    input  logic [63:0]        corners_b,
    input  logic signed [15:0] objectness_logit,
    input  logic [63:0]        color_logits,
    input  logic [63:0]        class_logits_low,
    input  logic [63:0]        class_logits_high,
    input  logic signed [15:0] class_logit_last,
    output logic               det_valid,
    input  logic               det_ready,
    output logic [15:0]        score,
    output logic               color_flag,
    output logic [3:0]         top_class,
    output logic [63:0]        clamped_corners_a,
    output logic [63:0]        clamped_corners_b,
    output logic [63:0]        box_packed,
    output logic [13:0]        edge_length,
    output logic [13:0]        edge_width,
    output logic [15:0]        aspect_ratio,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int NCLS = (NUM_CLASSES > CLASS_SLOTS) ? CLASS_SLOTS : NUM_CLASSES;
    localparam int NCOL = (NUM_COLORS > COLOR_SLOTS) ? COLOR_SLOTS : NUM_COLORS;
    localparam int LIM = COORD_LIMIT * 16;
    localparam int PIPE_DEPTH = 38;

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    logic adv;

    logic [1:0]  target_color_reg;
    logic [1:0]  target_color_next;
    logic [15:0] conf_threshold_reg;
    logic [15:0] conf_threshold_next;

    logic [PIPE_DEPTH-1:0] valid_reg;

    row_t row_s1_reg;

    logic signed [15:0] cls_s2_next [CLASS_SLOTS];
    logic signed [15:0] cls_s2_reg  [CLASS_SLOTS];
    logic signed [15:0] mx_s2_next;
    logic signed [15:0] mx_s2_reg;
    logic [3:0]         top_class_s2_next;
    logic [3:0]         top_class_s2_reg;
    logic [1:0]         color_s2_next;
    logic [1:0]         color_s2_reg;
    exp_arg_t           mag_s2_next;
    exp_arg_t           mag_s2_reg;
    logic               neg_s2_next;
    logic               neg_s2_reg;
    logic [7:0][15:0]   pt_s2_next;
    logic [7:0][15:0]   pt_s2_reg;

    exp_arg_t    diff_s3_next [CLASS_SLOTS];
    exp_arg_t    diff_s3_reg  [CLASS_SLOTS];
    logic [31:0] sq_s3_next   [4];
    logic [31:0] sq_s3_reg    [4];
    logic [63:0] box_s3_next;
    logic [63:0] box_s3_reg;

    sqrt_arg_t nlen_s4_reg;
    sqrt_arg_t nwid_s4_reg;

    exp_val_t e_obj_s14;
    logic     neg_s14;
    exp_val_t e_cls_s15 [CLASS_SLOTS];

    logic [26:0] grp_s16_next [3];
    logic [26:0] grp_s16_reg  [3];
    logic [27:0] sum_s17_reg;

    logic [25:0] obj_den;
    div_num_t    obj_num;
    div_num_t    prob_num;
    logic [15:0] obj_s31;
    logic [15:0] obj_s34;
    logic [15:0] prob_s34;
    logic [31:0] score_sum;
    logic [15:0] score_s35_reg;

    edge_t       len_s21;
    edge_t       wid_s21;
    div_num_t    ratio_num;
    logic [15:0] ratio_s38;

    logic [15:0]  obj_s38;
    logic [15:0]  score_s38;
    logic [5:0]   ids_s38;
    logic [127:0] pt_s38;
    logic [63:0]  box_s38;
    logic [27:0]  edges_s38;

    logic        keep;
    logic        det_valid_reg;
    logic [15:0] score_reg;
    logic        color_flag_reg;
    logic [3:0]  top_class_reg;
    logic [63:0] clamped_corners_a_reg;
    logic [63:0] clamped_corners_b_reg;
    logic [63:0] box_packed_reg;
    logic [13:0] edge_length_reg;
    logic [13:0] edge_width_reg;
    logic [15:0] aspect_ratio_reg;

    assign adv = !det_valid_reg || det_ready;
    assign row_ready = adv;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_comb
    begin
        target_color_next = target_color_reg;
        conf_threshold_next = conf_threshold_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TARGET_COLOR:   target_color_next = cfg_data[1:0];
                REG_CONF_THRESHOLD: conf_threshold_next = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_color_reg <= TARGET_COLOR_RESET;
            conf_threshold_reg <= CONF_THRESHOLD_RESET;
        end
        else
        begin
            target_color_reg <= target_color_next;
            conf_threshold_reg <= conf_threshold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], row_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row_s1_reg <= '{corners_a, corners_b, objectness_logit, color_logits,
                            class_logits_low, class_logits_high, class_logit_last};
        end
    end

    // argmax, objectness magnitude, corner clamp
    always_comb
    begin
        logic signed [15:0] col [COLOR_SLOTS];
        logic signed [15:0] cbest;
        logic signed [15:0] v;
        logic [16:0]        xe;
        for (int i = 0; i < 4; i++)
        begin
            cls_s2_next[i] = row_s1_reg.class_logits_low[16*i +: 16];
            cls_s2_next[i+4] = row_s1_reg.class_logits_high[16*i +: 16];
            col[i] = row_s1_reg.color_logits[16*i +: 16];
        end
        cls_s2_next[8] = row_s1_reg.class_logit_last;

        mx_s2_next = cls_s2_next[0];
        top_class_s2_next = '0;
        for (int i = 1; i < CLASS_SLOTS; i++)
        begin
            if (i < NCLS && cls_s2_next[i] > mx_s2_next)
            begin
                mx_s2_next = cls_s2_next[i];
                top_class_s2_next = 4'(i);
            end
        end

        cbest = col[0];
        color_s2_next = COLOR_0;
        for (int i = 1; i < COLOR_SLOTS; i++)
        begin
            if (i < NCOL && col[i] > cbest)
            begin
                cbest = col[i];
                color_s2_next = 2'(i);
            end
        end

        xe = {row_s1_reg.objectness_logit[15], row_s1_reg.objectness_logit};
        neg_s2_next = xe[16];
        mag_s2_next = xe[16] ? 16'(17'd0 - xe) : xe[15:0];

        for (int i = 0; i < CORNER_LANES; i++)
        begin
            v = (i < 4) ? row_s1_reg.corners_a[16*i +: 16]
                        : row_s1_reg.corners_b[16*(i-4) +: 16];
            if (v < 0)
            begin
                pt_s2_next[i] = '0;
            end
            else if (int'(v) > LIM)
            begin
                pt_s2_next[i] = 16'(LIM);
            end
            else
            begin
                pt_s2_next[i] = v;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_s2_reg <= cls_s2_next;
            mx_s2_reg <= mx_s2_next;
            top_class_s2_reg <= top_class_s2_next;
            color_s2_reg <= color_s2_next;
            mag_s2_reg <= mag_s2_next;
            neg_s2_reg <= neg_s2_next;
            pt_s2_reg <= pt_s2_next;
        end
    end

    // logit distances, squared deltas, bounding box
    always_comb
    begin
        logic signed [16:0] df;
        logic [15:0]        ad [4];
        logic [15:0]        mnx;
        logic [15:0]        mxx;
        logic [15:0]        mny;
        logic [15:0]        mxy;
        for (int i = 0; i < CLASS_SLOTS; i++)
        begin
            df = 17'(mx_s2_reg) - 17'(cls_s2_reg[i]);
            diff_s3_next[i] = df[15:0];
        end

        ad[0] = abs_diff(pt_s2_reg[0], pt_s2_reg[6]);
        ad[1] = abs_diff(pt_s2_reg[1], pt_s2_reg[7]);
        ad[2] = abs_diff(pt_s2_reg[0], pt_s2_reg[2]);
        ad[3] = abs_diff(pt_s2_reg[1], pt_s2_reg[3]);
        for (int j = 0; j < 4; j++)
        begin
            sq_s3_next[j] = 32'(ad[j]) * 32'(ad[j]);
        end

        mnx = pt_s2_reg[0];
        mxx = pt_s2_reg[0];
        mny = pt_s2_reg[1];
        mxy = pt_s2_reg[1];
        for (int i = 2; i < CORNER_LANES; i += 2)
        begin
            if (pt_s2_reg[i] < mnx) mnx = pt_s2_reg[i];
            if (pt_s2_reg[i] > mxx) mxx = pt_s2_reg[i];
            if (pt_s2_reg[i+1] < mny) mny = pt_s2_reg[i+1];
            if (pt_s2_reg[i+1] > mxy) mxy = pt_s2_reg[i+1];
        end
        box_s3_next = {16'((mxy - mny) >> 4), 16'((mxx - mnx) >> 4),
                       16'(mny >> 4), 16'(mnx >> 4)};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_s3_reg <= diff_s3_next;
            sq_s3_reg <= sq_s3_next;
            box_s3_reg <= box_s3_next;
            nlen_s4_reg <= sq_s3_reg[0] + sq_s3_reg[1];
            nwid_s4_reg <= sq_s3_reg[2] + sq_s3_reg[3];
        end
    end

    // objectness sigmoid
    krd_exp_pipe u_exp_obj (
        .clk    (clk),
        .en     (adv),
        .arg    (mag_s2_reg),
        .result (e_obj_s14)
    );

    krd_delay #(.WIDTH(1), .DEPTH(EXP_LAT)) u_dly_neg (
        .clk (clk),
        .en  (adv),
        .d   (neg_s2_reg),
        .q   (neg_s14)
    );

    always_comb
    begin
        obj_den = 26'(EXP_ONE) + 26'(e_obj_s14);
        obj_num = neg_s14 ? ({e_obj_s14, 16'b0} + 41'(obj_den >> 1))
                          : ((41'd1 << 40) + 41'(obj_den >> 1));
    end

    krd_div_pipe u_div_obj (
        .clk  (clk),
        .en   (adv),
        .num  (obj_num),
        .den  (DIV_DEN_W'(obj_den)),
        .quot (obj_s31)
    );

    krd_delay #(.WIDTH(16), .DEPTH(3)) u_dly_obj_a (
        .clk (clk),
        .en  (adv),
        .d   (obj_s31),
        .q   (obj_s34)
    );

    // top class probability
    for (genvar i = 0; i < CLASS_SLOTS; i++)
    begin : g_cls_exp
        krd_exp_pipe u_exp_cls (
            .clk    (clk),
            .en     (adv),
            .arg    (diff_s3_reg[i]),
            .result (e_cls_s15[i])
        );
    end

    always_comb
    begin
        for (int g = 0; g < 3; g++)
        begin
            grp_s16_next[g] = '0;
            for (int j = 0; j < 3; j++)
            begin
                if (3 * g + j < NCLS)
                begin
                    grp_s16_next[g] = grp_s16_next[g] + 27'(e_cls_s15[3*g+j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            grp_s16_reg <= grp_s16_next;
            sum_s17_reg <= 28'(grp_s16_reg[0]) + 28'(grp_s16_reg[1]) + 28'(grp_s16_reg[2]);
        end
    end

    assign prob_num = (41'd1 << 40) + 41'(sum_s17_reg >> 1);

    krd_div_pipe u_div_prob (
        .clk  (clk),
        .en   (adv),
        .num  (prob_num),
        .den  (sum_s17_reg),
        .quot (prob_s34)
    );

    assign score_sum = obj_s34 * prob_s34 + 32'd32768;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            score_s35_reg <= score_sum[31:16];
        end
    end

    // edge lengths and ratio
    krd_sqrt_pipe u_sqrt_len (
        .clk  (clk),
        .en   (adv),
        .arg  (nlen_s4_reg),
        .root (len_s21)
    );

    krd_sqrt_pipe u_sqrt_wid (
        .clk  (clk),
        .en   (adv),
        .arg  (nwid_s4_reg),
        .root (wid_s21)
    );

    assign ratio_num = 41'({len_s21, 8'h00}) + 41'(wid_s21 >> 1);

    krd_div_pipe u_div_ratio (
        .clk  (clk),
        .en   (adv),
        .num  (ratio_num),
        .den  (DIV_DEN_W'(wid_s21)),
        .quot (ratio_s38)
    );

    // alignment to the result stage
    krd_delay #(.WIDTH(16), .DEPTH(4)) u_dly_obj_b (
        .clk (clk),
        .en  (adv),
        .d   (obj_s34),
        .q   (obj_s38)
    );

    krd_delay #(.WIDTH(16), .DEPTH(3)) u_dly_score (
        .clk (clk),
        .en  (adv),
        .d   (score_s35_reg),
        .q   (score_s38)
    );

    krd_delay #(.WIDTH(6), .DEPTH(PIPE_DEPTH - 2)) u_dly_ids (
        .clk (clk),
        .en  (adv),
        .d   ({color_s2_reg, top_class_s2_reg}),
        .q   (ids_s38)
    );

    krd_delay #(.WIDTH(128), .DEPTH(PIPE_DEPTH - 2)) u_dly_pt (
        .clk (clk),
        .en  (adv),
        .d   (pt_s2_reg),
        .q   (pt_s38)
    );

    krd_delay #(.WIDTH(64), .DEPTH(PIPE_DEPTH - 3)) u_dly_box (
        .clk (clk),
        .en  (adv),
        .d   (box_s3_reg),
        .q   (box_s38)
    );

    krd_delay #(.WIDTH(28), .DEPTH(DIV_LAT)) u_dly_edges (
        .clk (clk),
        .en  (adv),
        .d   ({len_s21, wid_s21}),
        .q   (edges_s38)
    );

    // filter and output register
    always_comb
    begin
        keep = (ids_s38[5:4] == COLOR_0 || ids_s38[5:4] == COLOR_1)
            && !(target_color_reg == COLOR_0 && ids_s38[5:4] == COLOR_1)
            && !(target_color_reg == COLOR_1 && ids_s38[5:4] == COLOR_0)
            && (obj_s38 >= conf_threshold_reg)
            && (score_s38 >= conf_threshold_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            det_valid_reg <= valid_reg[PIPE_DEPTH-1] && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            score_reg <= score_s38;
            color_flag_reg <= (ids_s38[5:4] == COLOR_0);
            top_class_reg <= ids_s38[3:0];
            clamped_corners_a_reg <= pt_s38[63:0];
            clamped_corners_b_reg <= pt_s38[127:64];
            box_packed_reg <= box_s38;
            edge_length_reg <= edges_s38[27:14];
            edge_width_reg <= edges_s38[13:0];
            aspect_ratio_reg <= (edges_s38 == '0) ? 16'd0 : ratio_s38;
        end
    end

    assign det_valid = det_valid_reg;
    assign score = score_reg;
    assign color_flag = color_flag_reg;
    assign top_class = top_class_reg;
    assign clamped_corners_a = clamped_corners_a_reg;
    assign clamped_corners_b = clamped_corners_b_reg;
    assign box_packed = box_packed_reg;
    assign edge_length = edge_length_reg;
    assign edge_width = edge_width_reg;
    assign aspect_ratio = aspect_ratio_reg;

endmodule

`default_nettype wire

// ----- rtl/core/krd_exp_pipe.sv -----
// Pipelined exp(-t) in Q1.24, one argument bit per stage.
`default_nettype none

module krd_exp_pipe import krd_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  exp_arg_t arg,
    output exp_val_t result
);

    exp_val_t acc_reg [EXP_STEPS];
    exp_arg_t arg_reg [EXP_STEPS-1];

    for (genvar k = 0; k < EXP_STEPS; k++)
    begin : g_step
        exp_val_t    acc_in;
        exp_arg_t    arg_in;
        exp_val_t    acc_next;
        logic [48:0] prod;
        logic [48:0] rounded;

        if (k == 0)
        begin : g_first
            assign arg_in = arg;
            assign acc_in = (|arg[15:12]) ? '0 : EXP_ONE;
        end
        else
        begin : g_rest
            assign arg_in = arg_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        always_comb
        begin
            prod = {24'b0, acc_in} * {25'b0, exp_coef(k)};
            rounded = prod + (49'd1 << 23);
            acc_next = arg_in[k] ? rounded[48:24] : acc_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k] <= acc_next;
            end
        end

        if (k < EXP_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    arg_reg[k] <= arg_in;
                end
            end
        end
    end

    assign result = acc_reg[EXP_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/core/krd_div_pipe.sv -----
// Pipelined rounded-numerator divider, one quotient bit per stage, saturating to 16 bits.
`default_nettype none

module krd_div_pipe import krd_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  div_num_t    num,
    input  div_den_t    den,
    output logic [15:0] quot
);

    logic [DIV_Q_W-1:0] q_reg   [DIV_Q_W];
    logic               sat_reg [DIV_Q_W];
    div_den_t           rem_reg [DIV_Q_W-1];
    div_den_t           den_reg [DIV_Q_W-1];
    logic [DIV_Q_W-1:0] low_reg [DIV_Q_W-1];

    for (genvar k = 0; k < DIV_Q_W; k++)
    begin : g_step
        div_den_t           rem_in;
        div_den_t           den_in;
        logic [DIV_Q_W-1:0] low_in;
        logic [DIV_Q_W-1:0] q_in;
        logic               sat_in;
        logic [DIV_DEN_W:0] trial;
        logic               ge;
        div_den_t           rem_next;
        logic [DIV_Q_W-1:0] q_next;
        logic [DIV_Q_W-1:0] low_next;

        if (k == 0)
        begin : g_first
            assign rem_in = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
            assign den_in = den;
            assign low_in = num[DIV_Q_W-1:0];
            assign q_in = '0;
            assign sat_in = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]) >= den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in = q_reg[k-1];
            assign sat_in = sat_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, low_in[DIV_Q_W-1]};
            ge = trial >= {1'b0, den_in};
            rem_next = ge ? DIV_DEN_W'(trial - {1'b0, den_in}) : trial[DIV_DEN_W-1:0];
            q_next = {q_in[DIV_Q_W-2:0], ge};
            low_next = {low_in[DIV_Q_W-2:0], 1'b0};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= q_next;
                sat_reg[k] <= sat_in;
            end
        end

        if (k < DIV_Q_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    low_reg[k] <= low_next;
                end
            end
        end
    end

    assign quot = (sat_reg[DIV_Q_W-1] || q_reg[DIV_Q_W-1][DIV_Q_W-1]) ?
                  16'hFFFF : q_reg[DIV_Q_W-1][15:0];

endmodule

`default_nettype wire

// ----- rtl/core/krd_sqrt_pipe.sv -----
// Pipelined integer square root with round-to-nearest and 14-bit saturation.
`default_nettype none

module krd_sqrt_pipe import krd_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  sqrt_arg_t arg,
    output edge_t     root
);

    sqrt_arg_t m_reg [SQRT_STEPS];
    sqrt_arg_t r_reg [SQRT_STEPS];
    edge_t     root_reg;
    edge_t     root_next;
    logic [16:0] rounded;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_step
        localparam sqrt_arg_t BIT = 32'h1 << (30 - 2 * i);
        sqrt_arg_t m_in;
        sqrt_arg_t r_in;
        sqrt_arg_t trial;
        logic      ge;
        sqrt_arg_t m_next;
        sqrt_arg_t r_next;

        if (i == 0)
        begin : g_first
            assign m_in = arg;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign m_in = m_reg[i-1];
            assign r_in = r_reg[i-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            ge = m_in >= trial;
            m_next = ge ? m_in - trial : m_in;
            r_next = ge ? (r_in >> 1) + BIT : r_in >> 1;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i] <= m_next;
                r_reg[i] <= r_next;
            end
        end
    end

    always_comb
    begin
        rounded = r_reg[SQRT_STEPS-1][16:0]
                + 17'(m_reg[SQRT_STEPS-1] > r_reg[SQRT_STEPS-1]);
        root_next = (rounded > 17'd16383) ? 14'h3FFF : rounded[13:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= root_next;
        end
    end

    assign root = root_reg;

endmodule

`default_nettype wire

// ----- rtl/core/krd_delay.sv -----
// Enabled delay line that keeps side data aligned with the arithmetic units.
`default_nettype none

module krd_delay #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/core/krd_checker.sv -----
// Port-level assertions for the keypoint row decoder and their bind.
`default_nettype none

module krd_checker #(
    parameter int COORD_LIMIT = 640
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        row_ready,
    input logic        det_valid,
    input logic        det_ready,
    input logic [15:0] score,
    input logic [63:0] box_packed,
    input logic [13:0] edge_length,
    input logic [13:0] edge_width,
    input logic [15:0] aspect_ratio
);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !det_valid |-> row_ready)
        else $error("row channel blocked with no result pending");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid && !det_ready |=> det_valid && $stable(score) && $stable(box_packed)
                                    && $stable(aspect_ratio))
        else $error("result changed while stalled");

    a_ratio_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid && edge_width == 14'd0 && edge_length != 14'd0 |->
        aspect_ratio == 16'hFFFF)
        else $error("aspect ratio not saturated for zero width");

    a_box_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid |-> (17'(box_packed[15:0]) + 17'(box_packed[47:32]) <= 17'(COORD_LIMIT))
                   && (17'(box_packed[31:16]) + 17'(box_packed[63:48]) <= 17'(COORD_LIMIT)))
        else $error("bounding box leaves the frame");

endmodule

bind keypoint_detection_row_decoder krd_checker #(.COORD_LIMIT(COORD_LIMIT)) u_krd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .row_ready    (row_ready),
    .det_valid    (det_valid),
    .det_ready    (det_ready),
    .score        (score),
    .box_packed   (box_packed),
    .edge_length  (edge_length),
    .edge_width   (edge_width),
    .aspect_ratio (aspect_ratio)
);

`default_nettype wire
